// ===== sv/mash_process_sequencer_macros.svh =====
// Assertion helpers shared by the sequencer RTL.
`ifndef MASH_PROCESS_SEQUENCER_MACROS_SVH
`define MASH_PROCESS_SEQUENCER_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define MPS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define MPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/mps_pkg.sv =====
package mps_pkg;

  localparam int TEMP_W  = 12;
  localparam int MIN_W   = 8;
  localparam int PHASE_W = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  // Phase codes
  localparam logic [PHASE_W-1:0] PH_START     = 3'd0;
  localparam logic [PHASE_W-1:0] PH_INIT      = 3'd1;
  localparam logic [PHASE_W-1:0] PH_PREMASH   = 3'd2;
  localparam logic [PHASE_W-1:0] PH_TRANSFER  = 3'd3;
  localparam logic [PHASE_W-1:0] PH_MASH      = 3'd4;
  localparam logic [PHASE_W-1:0] PH_PRESPARGE = 3'd5;
  localparam logic [PHASE_W-1:0] PH_SPARGE    = 3'd6;
  localparam logic [PHASE_W-1:0] PH_END       = 3'd7;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MASH_TARGET   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPARGE_TARGET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MASH_MINUTES  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOIL_FITTED   = 2'd3;

  // Reset values of the configuration registers
  localparam logic [TEMP_W-1:0] MASH_TARGET_RST   = 12'd2432;
  localparam logic [TEMP_W-1:0] SPARGE_TARGET_RST = 12'd2720;
  localparam logic [MIN_W-1:0]  MASH_MINUTES_RST  = 8'd60;

  typedef struct packed {
    logic [TEMP_W-1:0] hlt_temp;
    logic [TEMP_W-1:0] mash_tun_temp;
    logic              hlt_empty;
    logic              mash_full;
    logic              mash_empty;
    logic [MIN_W-1:0]  minutes_elapsed;
  } in_item_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic               heater_on;
    logic               hlt_pump_on;
    logic               mash_pump_on;
    logic               boil_pump_on;
    logic               timer_start;
    logic               timer_stop;
  } out_item_t;

endpackage

// ===== sv/mps_chan_if.sv =====
interface mps_chan_if #(
  parameter type item_t = logic
);
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/mash_process_sequencer.sv =====
// Mash process sequencer: one result transaction per input transaction.
// Latency: the result is valid in the cycle after the input is accepted.
// Throughput: one transaction per clock; the single result register is the
// only stage, so input is taken whenever that register is empty or drained.
// Reset (rst, synchronous, active high): phase back to start, all drives off,
// counters cleared, configuration registers at their default values.
`include "mash_process_sequencer_macros.svh"

module mash_process_sequencer
  import mps_pkg::*;
#(
  parameter int CONFIRM_TICKS = 3,   // 1..4
  parameter int PRIME_TICKS   = 30,  // 1..31
  parameter int HEAT_MARGIN   = 160  // 0..1023, 1/16 degree F
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  mps_chan_if.sink              in_chan,
  mps_chan_if.source            out_chan
);

  localparam logic [2:0]        CONFIRM_LIMIT = 3'(CONFIRM_TICKS);
  localparam logic [4:0]        PRIME_LIMIT   = 5'(PRIME_TICKS);
  localparam logic [TEMP_W:0]   MARGIN        = (TEMP_W+1)'(HEAT_MARGIN);

  // Configuration registers
  logic [TEMP_W-1:0] mash_target;
  logic [TEMP_W-1:0] sparge_target;
  logic [MIN_W-1:0]  mash_minutes;
  logic              boil_pump_fitted;

  // Sequencer state
  logic [PHASE_W-1:0] phase_reg,     phase_next;
  logic [1:0]         confirm_count, confirm_count_next;
  logic [4:0]         prime_count,   prime_count_next;
  logic heater_reg,    heater_next;
  logic hlt_pump_reg,  hlt_pump_next;
  logic mash_pump_reg, mash_pump_next;
  logic boil_pump_reg, boil_pump_next;

  // Result register
  logic      out_valid;
  out_item_t out_data;

  logic     accept;
  in_item_t item;

  // Per-phase condition that has to be confirmed
  logic               use_confirm;
  logic               cond;
  logic [PHASE_W-1:0] adv_phase;
  logic               fire;
  logic               hot;
  logic               t_start;
  logic               t_stop;

  assign item          = in_chan.data;
  assign in_chan.ready = !out_valid || out_chan.ready;
  assign accept        = in_chan.valid && in_chan.ready;

  assign out_chan.valid = out_valid;
  assign out_chan.data  = out_data;

  // Mash-phase thermostat: sum kept one bit wider so it never wraps.
  assign hot = ({1'b0, item.hlt_temp} >= ({1'b0, mash_target} + MARGIN));

  always_comb begin
    use_confirm = 1'b0;
    cond        = 1'b0;
    adv_phase   = phase_reg;
    phase_next  = phase_reg;
    t_stop      = 1'b0;
    case (phase_reg)
      PH_INIT: begin
        phase_next = PH_PREMASH;
      end
      PH_PREMASH: begin
        use_confirm = 1'b1;
        cond        = item.hlt_temp >= mash_target;
        adv_phase   = PH_TRANSFER;
      end
      PH_TRANSFER: begin
        use_confirm = 1'b1;
        cond        = item.hlt_empty || item.mash_full;
        adv_phase   = PH_MASH;
      end
      PH_MASH: begin
        // timed step, no confirmation
        if (item.minutes_elapsed >= mash_minutes) begin
          t_stop     = 1'b1;
          phase_next = PH_PRESPARGE;
        end
      end
      PH_PRESPARGE: begin
        use_confirm = 1'b1;
        cond        = item.hlt_temp >= sparge_target;
        adv_phase   = PH_SPARGE;
      end
      PH_SPARGE: begin
        use_confirm = 1'b1;
        cond        = item.hlt_empty && item.mash_empty;
        adv_phase   = PH_END;
      end
      PH_END: begin
        phase_next = PH_END;
      end
      default: begin
        // start phase
        phase_next = PH_INIT;
      end
    endcase

    // Confirm counter: cleared on a miss and on every advance.
    fire               = 1'b0;
    confirm_count_next = confirm_count;
    if (use_confirm) begin
      if (!cond) begin
        confirm_count_next = 2'd0;
      end else if (({1'b0, confirm_count} + 3'd1) >= CONFIRM_LIMIT) begin
        confirm_count_next = 2'd0;
        fire               = 1'b1;
      end else begin
        confirm_count_next = confirm_count + 2'd1;
      end
    end
    if (fire) begin
      phase_next = adv_phase;
    end
    t_start = fire && (phase_reg == PH_TRANSFER);

    // Drive actions of the phase after the update
    heater_next      = heater_reg;
    hlt_pump_next    = hlt_pump_reg;
    mash_pump_next   = mash_pump_reg;
    boil_pump_next   = boil_pump_reg;
    prime_count_next = prime_count;
    case (phase_next)
      PH_PREMASH: begin
        heater_next = 1'b1;
      end
      PH_TRANSFER: begin
        heater_next   = 1'b0;
        hlt_pump_next = 1'b1;
      end
      PH_MASH: begin
        heater_next    = !hot;
        mash_pump_next = hot && (item.mash_tun_temp < mash_target);
      end
      PH_PRESPARGE: begin
        mash_pump_next = 1'b0;
        heater_next    = 1'b1;
      end
      PH_SPARGE: begin
        heater_next = 1'b0;
        if (prime_count < PRIME_LIMIT) begin
          // priming the mash pump
          prime_count_next = prime_count + 5'd1;
          mash_pump_next   = 1'b1;
        end else if (boil_pump_fitted) begin
          hlt_pump_next  = !item.hlt_empty;
          boil_pump_next = !item.mash_empty;
        end
      end
      PH_END: begin
        heater_next    = 1'b0;
        hlt_pump_next  = 1'b0;
        mash_pump_next = 1'b0;
        boil_pump_next = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      mash_target      <= MASH_TARGET_RST;
      sparge_target    <= SPARGE_TARGET_RST;
      mash_minutes     <= MASH_MINUTES_RST;
      boil_pump_fitted <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MASH_TARGET:   mash_target      <= cfg_data[TEMP_W-1:0];
        REG_SPARGE_TARGET: sparge_target    <= cfg_data[TEMP_W-1:0];
        REG_MASH_MINUTES:  mash_minutes     <= cfg_data[MIN_W-1:0];
        REG_BOIL_FITTED:   boil_pump_fitted <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // State update on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg     <= PH_START;
      confirm_count <= 2'd0;
      prime_count   <= 5'd0;
      heater_reg    <= 1'b0;
      hlt_pump_reg  <= 1'b0;
      mash_pump_reg <= 1'b0;
      boil_pump_reg <= 1'b0;
    end else if (accept) begin
      phase_reg     <= phase_next;
      confirm_count <= confirm_count_next;
      prime_count   <= prime_count_next;
      heater_reg    <= heater_next;
      hlt_pump_reg  <= hlt_pump_next;
      mash_pump_reg <= mash_pump_next;
      boil_pump_reg <= boil_pump_next;
    end
  end

  // Result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload; boil pump output gated by the fitted flag
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data.phase        <= phase_next;
      out_data.heater_on    <= heater_next;
      out_data.hlt_pump_on  <= hlt_pump_next;
      out_data.mash_pump_on <= mash_pump_next;
      out_data.boil_pump_on <= boil_pump_next && boil_pump_fitted;
      out_data.timer_start  <= t_start;
      out_data.timer_stop   <= t_stop;
    end
  end

  // Checks
  `MPS_ASSERT_NOW(a_confirm_range, clk, rst, 1'b1,
    {1'b0, confirm_count} < CONFIRM_LIMIT, "confirm counter out of range")
  `MPS_ASSERT_NOW(a_timer_excl, clk, rst, out_valid,
    !(out_data.timer_start && out_data.timer_stop), "timer start and stop together")
  `MPS_ASSERT_NOW(a_start_phase, clk, rst, out_valid && out_data.timer_start,
    out_data.phase == PH_MASH, "timer start outside mash entry")
  `MPS_ASSERT_NEXT(a_result_follows, clk, rst, accept,
    out_valid && (out_data.phase == phase_reg), "accepted item left no result")

endmodule
